FILE: rtl/apse_pkg.sv
package apse_pkg;

	// Default width of the record byte counter
	localparam int OFFSET_BITS_DEF = 24;
	// Default depth of the queue between parser and expander
	localparam int QUEUE_DEPTH_DEF = 4;

	// Register map
	localparam int REG_W  = 24;
	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_RECORD_LENGTH = 1'b0;

	// Result event codes
	localparam logic [1:0] EV_DATA    = 2'd0;
	localparam logic [1:0] EV_DONE    = 2'd1;
	localparam logic [1:0] EV_LENSIZE = 2'd2;
	localparam logic [1:0] EV_OVERRUN = 2'd3;

	// Unit kinds
	localparam logic KIND_SPS = 1'b0;
	localparam logic KIND_PPS = 1'b1;

	// One input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       record_start;
	} in_item_t;

	// One result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       unit_kind;
		logic       unit_last;
		logic [1:0] event_res;
		logic       run_last;
	} out_item_t;

	// Work for the expander, one per input byte that has results
	typedef struct packed {
		logic [7:0] data_byte;
		logic       kind;
		logic       start;      // start code goes in front
		logic       data;       // NAL byte is emitted
		logic       unit_last;
		logic [1:0] ev;         // event after the data, EV_DATA for none
	} cmd_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

FILE: rtl/avcc_parameter_set_extractor.sv
// Channel   Handshake          Payload                 Accepted when
// record    push / full        record_item (in_item_t) push && !full
// result    pop / empty        result_item (out_item_t) pop && !empty
// config    APB psel/penable   paddr, pwdata, prdata   psel && penable && pwrite
//
// A record byte is taken every cycle while the parser-to-expander queue has room.
// The expander gives one result per cycle from its output register while pop is
// high, so a byte opening a kept unit yields up to six results; the queue absorbs them.
// Reset (arst_n low) clears parser state, queue, expander and record_length.
// A stalled result side fills the queue, then full rises and holds input off.
module avcc_parameter_set_extractor #(
	parameter int OFFSET_BITS = apse_pkg::OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = apse_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  apse_pkg::in_item_t          record_item,
	output logic                        empty,
	input  logic                        pop,
	output apse_pkg::out_item_t         result_item,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [apse_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [apse_pkg::REG_W-1:0] record_length_q;
	logic                       reg_hit;
	apse_pkg::qstat_t           qstat;
	logic                       cmd_push;
	apse_pkg::cmd_t             cmd_in;
	apse_pkg::cmd_t             cmd_out;
	logic                       q_pop;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[apse_pkg::ADDR_W-1] == apse_pkg::REG_RECORD_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			record_length_q <= '0;
		else if (psel && penable && pwrite && reg_hit)
			record_length_q <= pwdata[apse_pkg::REG_W-1:0];
	end

	assign prdata = reg_hit ? {8'h00, record_length_q} : 32'h0;
	assign full   = qstat.full;

	apse_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.item         (record_item),
		.record_length(record_length_q),
		.qstat        (qstat),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in)
	);

	apse_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_in),
		.rd_en  (q_pop),
		.rd_data(cmd_out),
		.qstat  (qstat)
	);

	apse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (cmd_out),
		.qstat      (qstat),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.result_item(result_item)
	);

endmodule

FILE: rtl/apse_front.sv
module apse_front #(
	parameter int OFFSET_BITS = apse_pkg::OFFSET_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  apse_pkg::in_item_t               item,
	input  logic [apse_pkg::REG_W-1:0]       record_length,
	input  apse_pkg::qstat_t                 qstat,
	output logic                             cmd_push,
	output apse_pkg::cmd_t                   cmd
);

	// Parser phases
	localparam logic [3:0] PH_HEADER  = 4'd0;
	localparam logic [3:0] PH_LENSIZE = 4'd1;
	localparam logic [3:0] PH_SPSCNT  = 4'd2;
	localparam logic [3:0] PH_LENHI   = 4'd3;
	localparam logic [3:0] PH_LENLO   = 4'd4;
	localparam logic [3:0] PH_FIRST   = 4'd5;
	localparam logic [3:0] PH_BODY    = 4'd6;
	localparam logic [3:0] PH_PPSCNT  = 4'd7;
	localparam logic [3:0] PH_DONE    = 4'd8;
	localparam logic [3:0] PH_ERROR   = 4'd9;

	// Width of the bounds sum
	localparam int SW = ((OFFSET_BITS > apse_pkg::REG_W) ? OFFSET_BITS : apse_pkg::REG_W) + 2;

	logic [3:0]             phase_q, phase_d, phase_c;
	logic [OFFSET_BITS-1:0] offset_q, offset_d, offset_c;
	logic [7:0]             units_q, units_d, units_c;
	logic [15:0]            ubl_q, ubl_d, ubl_c;
	logic [7:0]             lenhi_q, lenhi_d, lenhi_c;
	logic                   in_pps_q, in_pps_d, in_pps_c;
	logic                   sps_cap_q, sps_cap_d, sps_cap_c;
	logic                   pps_cap_q, pps_cap_d, pps_cap_c;
	logic                   keep_q, keep_d, keep_c;
	logic                   kind_q, kind_d, kind_c;

	logic                   accept;
	logic [7:0]             b;
	logic [15:0]            unit_len;
	logic [SW-1:0]          bound_sum;
	logic [4:0]             nal_type;
	logic                   body;
	logic                   ended;
	logic [15:0]            ubl_dec;
	logic [7:0]             units_dec;
	apse_pkg::cmd_t         cmd_c;

	assign accept   = push && !qstat.full;
	assign b        = item.data_byte;
	assign unit_len = {lenhi_c, b};
	assign bound_sum = SW'(offset_c) + SW'(1) + SW'(unit_len);
	assign nal_type = b[4:0];
	assign ubl_dec  = ubl_c - 16'd1;
	assign units_dec = units_c - 8'd1;

	// State as seen by this byte: a record start restarts the parser
	always_comb begin
		if (item.record_start) begin
			phase_c   = PH_HEADER;
			offset_c  = '0;
			units_c   = '0;
			ubl_c     = '0;
			lenhi_c   = '0;
			in_pps_c  = 1'b0;
			sps_cap_c = 1'b0;
			pps_cap_c = 1'b0;
			keep_c    = 1'b0;
			kind_c    = apse_pkg::KIND_SPS;
		end else begin
			phase_c   = phase_q;
			offset_c  = offset_q;
			units_c   = units_q;
			ubl_c     = ubl_q;
			lenhi_c   = lenhi_q;
			in_pps_c  = in_pps_q;
			sps_cap_c = sps_cap_q;
			pps_cap_c = pps_cap_q;
			keep_c    = keep_q;
			kind_c    = kind_q;
		end
	end

	// Parser next state and command
	always_comb begin
		phase_d   = phase_c;
		offset_d  = (offset_c != '1) ? offset_c + OFFSET_BITS'(1) : offset_c;
		units_d   = units_c;
		ubl_d     = ubl_c;
		lenhi_d   = lenhi_c;
		in_pps_d  = in_pps_c;
		sps_cap_d = sps_cap_c;
		pps_cap_d = pps_cap_c;
		keep_d    = keep_c;
		kind_d    = kind_c;
		body      = 1'b0;
		ended     = 1'b0;
		cmd_c           = '0;
		cmd_c.data_byte = b;
		cmd_c.ev        = apse_pkg::EV_DATA;

		case (phase_c)
			PH_HEADER: begin
				if (offset_c >= OFFSET_BITS'(3))
					phase_d = PH_LENSIZE;
			end
			PH_LENSIZE: begin
				if (b[1:0] == 2'd2) begin
					phase_d  = PH_ERROR;
					cmd_c.ev = apse_pkg::EV_LENSIZE;
				end else begin
					phase_d = PH_SPSCNT;
				end
			end
			PH_SPSCNT: begin
				units_d = {3'b000, b[4:0]};
				if (b[4:0] == 5'd0) begin
					in_pps_d = 1'b1;
					phase_d  = PH_PPSCNT;
				end else begin
					phase_d = PH_LENHI;
				end
			end
			PH_PPSCNT: begin
				units_d = b;
				if (b == 8'd0) begin
					phase_d  = PH_DONE;
					cmd_c.ev = apse_pkg::EV_DONE;
				end else begin
					phase_d = PH_LENHI;
				end
			end
			PH_LENHI: begin
				lenhi_d = b;
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				ubl_d = unit_len;
				if (bound_sum > SW'(record_length)) begin
					phase_d  = PH_ERROR;
					cmd_c.ev = apse_pkg::EV_OVERRUN;
				end else if (unit_len == 16'd0) begin
					ended = 1'b1;
				end else begin
					phase_d = PH_FIRST;
				end
			end
			PH_FIRST: begin
				keep_d = 1'b0;
				if (nal_type == 5'd7 && !sps_cap_c) begin
					sps_cap_d = 1'b1;
					keep_d    = 1'b1;
					kind_d    = apse_pkg::KIND_SPS;
				end else if (nal_type == 5'd8 && !pps_cap_c) begin
					pps_cap_d = 1'b1;
					keep_d    = 1'b1;
					kind_d    = apse_pkg::KIND_PPS;
				end
				cmd_c.start = keep_d;
				body        = 1'b1;
			end
			PH_BODY: begin
				body = 1'b1;
			end
			default: begin
			end
		endcase

		// NAL byte of a unit
		if (body) begin
			ubl_d           = ubl_dec;
			cmd_c.data      = keep_d;
			cmd_c.kind      = kind_d;
			cmd_c.unit_last = (ubl_dec == 16'd0);
			if (ubl_dec == 16'd0)
				ended = 1'b1;
			else
				phase_d = PH_BODY;
		end

		// End of a unit: next unit, next section or finish
		if (ended) begin
			units_d = units_dec;
			if (units_dec != 8'd0) begin
				phase_d = PH_LENHI;
			end else if (!in_pps_c) begin
				in_pps_d = 1'b1;
				phase_d  = PH_PPSCNT;
			end else begin
				phase_d  = PH_DONE;
				cmd_c.ev = apse_pkg::EV_DONE;
			end
		end
	end

	assign cmd      = cmd_c;
	assign cmd_push = accept && (cmd_c.start || cmd_c.data || cmd_c.ev != apse_pkg::EV_DATA);

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			offset_q  <= '0;
			units_q   <= '0;
			ubl_q     <= '0;
			lenhi_q   <= '0;
			in_pps_q  <= 1'b0;
			sps_cap_q <= 1'b0;
			pps_cap_q <= 1'b0;
			keep_q    <= 1'b0;
			kind_q    <= apse_pkg::KIND_SPS;
		end else if (accept) begin
			phase_q   <= phase_d;
			offset_q  <= offset_d;
			units_q   <= units_d;
			ubl_q     <= ubl_d;
			lenhi_q   <= lenhi_d;
			in_pps_q  <= in_pps_d;
			sps_cap_q <= sps_cap_d;
			pps_cap_q <= pps_cap_d;
			keep_q    <= keep_d;
			kind_q    <= kind_d;
		end
	end

endmodule

FILE: rtl/apse_queue.sv
module apse_queue #(
	parameter int DEPTH = apse_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  apse_pkg::cmd_t   wr_data,
	input  logic             rd_en,
	output apse_pkg::cmd_t   rd_data,
	output apse_pkg::qstat_t qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	apse_pkg::cmd_t slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign qstat.empty = (count_q == CW'(0));
	assign qstat.full  = (count_q == CW'(DEPTH));
	assign do_wr       = wr_en && !qstat.full;
	assign do_rd       = rd_en && !qstat.empty;
	assign rd_data     = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

FILE: rtl/apse_back.sv
module apse_back (
	input  logic                clk,
	input  logic                arst_n,
	input  apse_pkg::cmd_t      q_data,
	input  apse_pkg::qstat_t    qstat,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output apse_pkg::out_item_t result_item
);

	// Expansion steps
	localparam logic [2:0] ST_SC0  = 3'd0;
	localparam logic [2:0] ST_SC1  = 3'd1;
	localparam logic [2:0] ST_SC2  = 3'd2;
	localparam logic [2:0] ST_SC3  = 3'd3;
	localparam logic [2:0] ST_DATA = 3'd4;
	localparam logic [2:0] ST_EV   = 3'd5;

	apse_pkg::cmd_t      cmd_q;
	logic                cmd_valid_q;
	logic [2:0]          step_q;
	logic [2:0]          step_nx;
	logic                is_last;
	logic                adv;
	logic                finish;
	apse_pkg::out_item_t res_c;
	apse_pkg::out_item_t out_q;
	logic                out_valid_q;

	// First step of a command
	function automatic logic [2:0] first_step(input apse_pkg::cmd_t c);
		logic [2:0] s;
		if (c.start)
			s = ST_SC0;
		else if (c.data)
			s = ST_DATA;
		else
			s = ST_EV;
		return s;
	endfunction

	// Result for the current step
	always_comb begin
		res_c           = '0;
		res_c.unit_kind = cmd_q.kind;
		res_c.event_res = apse_pkg::EV_DATA;
		step_nx         = step_q;
		is_last         = 1'b0;
		case (step_q)
			ST_SC0, ST_SC1, ST_SC2: begin
				res_c.out_byte = 8'h00;
				step_nx        = step_q + 3'd1;
			end
			ST_SC3: begin
				res_c.out_byte = 8'h01;
				step_nx        = ST_DATA;
			end
			ST_DATA: begin
				res_c.out_byte  = cmd_q.data_byte;
				res_c.unit_last = cmd_q.unit_last;
				step_nx         = ST_EV;
				is_last         = (cmd_q.ev == apse_pkg::EV_DATA);
			end
			default: begin
				res_c.unit_kind = apse_pkg::KIND_SPS;
				res_c.event_res = cmd_q.ev;
				is_last         = 1'b1;
			end
		endcase
		res_c.run_last = is_last;
	end

	assign adv    = !out_valid_q || pop;
	assign finish = cmd_valid_q && adv && is_last;
	assign q_pop  = (!cmd_valid_q || finish) && !qstat.empty;

	// Command register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			step_q      <= ST_SC0;
		end else if (q_pop) begin
			cmd_valid_q <= 1'b1;
			step_q      <= first_step(q_data);
		end else if (finish) begin
			cmd_valid_q <= 1'b0;
		end else if (cmd_valid_q && adv) begin
			step_q <= step_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cmd_q <= q_data;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= cmd_valid_q;
	end

	always_ff @(posedge clk) begin
		if (adv && cmd_valid_q)
			out_q <= res_c;
	end

	assign empty       = !out_valid_q;
	assign result_item = out_q;

endmodule
